// ===== sv/ecv_pkg.sv =====
// Package: widths, stage counts and payload types for the 2-D elastic collision core.
`timescale 1ns / 1ps
`default_nettype none

package ecv_pkg;

    localparam int V_W       = 16;
    localparam int D_W       = V_W + 1;
    localparam int PROD_W    = 2 * D_W;
    localparam int SQ_W      = 2 * V_W;
    localparam int DOT_W     = PROD_W + 1;
    localparam int ADOT_W    = 2 * V_W + 1;
    localparam int LEN_W     = SQ_W + 1;
    localparam int MD_W      = 2 * V_W;
    localparam int DEN_W     = D_W + LEN_W;
    localparam int LO_W      = 17;
    localparam int HI_W      = ADOT_W - LO_W;
    localparam int PLO_W     = MD_W + LO_W;
    localparam int PHI_W     = MD_W + HI_W;
    localparam int SUM_W     = MD_W + ADOT_W;
    localparam int NUM_W     = SUM_W + 1;
    localparam int QB        = 18;
    localparam int DIV_STEPS = QB;
    localparam int DSH_W     = DEN_W + QB - 1;
    localparam int CMP_W     = NUM_W + 1;
    localparam int ACC_W     = V_W + 4;
    localparam int PRE_STG   = 6;
    localparam int NSTAGE    = PRE_STG + DIV_STEPS + 1;
    localparam int NLANE     = 4;

    typedef logic [DIV_STEPS-1:0] unused_t;

    typedef struct packed {
        logic [NLANE-1:0][V_W-1:0] v;
        logic                      bad;
        logic                      dxn;
        logic                      dyn;
        logic                      dotn;
    } carry_t;

endpackage

`default_nettype wire

// ===== sv/elastic_collision_2d_vector_core.sv =====
// Top level: fully pipelined 2-D elastic collision of one contact pair per cycle.
// Stages from input transfer to result valid: 6 arithmetic stages,
// 18 restoring divider stages and the output register.
// Throughput: one pair per cycle while the output is not stalled; all stages are registered.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst_n, async, active low) clears all valid bits; payload is not reset.
`timescale 1ns / 1ps
`default_nettype none

module elastic_collision_2d_vector_core
    import ecv_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic signed [V_W-1:0] vel_a_x,
    input  wire logic signed [V_W-1:0] vel_a_y,
    input  wire logic signed [V_W-1:0] vel_b_x,
    input  wire logic signed [V_W-1:0] vel_b_y,
    input  wire logic        [V_W-1:0] mass_a,
    input  wire logic        [V_W-1:0] mass_b,
    input  wire logic signed [V_W-1:0] pos_a_x,
    input  wire logic signed [V_W-1:0] pos_a_y,
    input  wire logic signed [V_W-1:0] pos_b_x,
    input  wire logic signed [V_W-1:0] pos_b_y,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic signed [V_W-1:0]      new_vel_a_x,
    output logic signed [V_W-1:0]      new_vel_a_y,
    output logic signed [V_W-1:0]      new_vel_b_x,
    output logic signed [V_W-1:0]      new_vel_b_y,
    output logic                       bad_pair
);

    logic                    advance;
    logic [NSTAGE-1:0]       vld_reg;
    logic [NSTAGE-1:0]       vld_next;

    // s0
    carry_t                  c0_reg;
    logic signed [D_W-1:0]   dvx0_reg, dvy0_reg, dx0_reg, dy0_reg;
    logic        [D_W-1:0]   msum0_reg;
    logic        [V_W-1:0]   ma0_reg, mb0_reg;
    // s1
    carry_t                  c1_reg;
    logic signed [PROD_W-1:0] pxx1_reg, pyy1_reg, sxx1_reg, syy1_reg;
    logic        [V_W-1:0]   adx1_reg, ady1_reg, ma1_reg, mb1_reg;
    logic        [D_W-1:0]   msum1_reg;
    // s2
    carry_t                  c2_reg;
    logic signed [DOT_W-1:0] dot2_reg;
    logic        [LEN_W-1:0] len2_reg;
    logic        [D_W-1:0]   msum2_reg;
    logic        [MD_W-1:0]  md2_reg [NLANE];
    // s3
    carry_t                  c3_reg;
    logic        [ADOT_W-1:0] adot3_reg;
    logic        [DEN_W-1:0] den3_reg;
    logic        [MD_W-1:0]  md3_reg [NLANE];
    // s4
    carry_t                  c4_reg;
    logic        [DEN_W-1:0] den4_reg;
    logic        [PLO_W-1:0] plo4_reg [NLANE];
    logic        [PHI_W-1:0] phi4_reg [NLANE];
    // s5
    carry_t                  c5_reg;
    logic        [DEN_W-1:0] den5_reg;
    logic        [NUM_W-1:0] num5_reg [NLANE];
    // divider
    carry_t                  cd_reg   [DIV_STEPS];
    logic        [DEN_W-1:0] dend_reg [DIV_STEPS];
    logic        [NUM_W-1:0] rem_reg  [DIV_STEPS][NLANE];
    logic        [QB-1:0]    q_reg    [DIV_STEPS][NLANE];
    logic        [NUM_W-1:0] rem_next [DIV_STEPS][NLANE];
    logic        [QB-1:0]    q_next   [DIV_STEPS][NLANE];
    // output
    logic signed [V_W-1:0]   res_next [NLANE];
    logic signed [V_W-1:0]   res_reg  [NLANE];
    logic                    bad_reg;

    logic signed [D_W-1:0]   dx_in, dy_in;
    logic signed [DOT_W-1:0] dot_neg;
    logic        [SUM_W-1:0] psum [NLANE];

    assign advance  = !vld_reg[NSTAGE-1] || !out_stall;
    assign in_stall = !advance;
    assign vld_next = {vld_reg[NSTAGE-2:0], in_valid};

    assign dx_in   = {pos_a_x[V_W-1], pos_a_x} - {pos_b_x[V_W-1], pos_b_x};
    assign dy_in   = {pos_a_y[V_W-1], pos_a_y} - {pos_b_y[V_W-1], pos_b_y};
    assign dot_neg = DOT_W'(0) - dot2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= vld_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NLANE; i++)
        begin
            psum[i] = SUM_W'(plo4_reg[i]) + SUM_W'({phi4_reg[i], {LO_W{1'b0}}});
        end
    end

    // one quotient bit per stage, most significant first; top bit marks saturation
    always_comb
    begin
        logic [CMP_W-1:0] rin;
        logic [CMP_W-1:0] dsh;
        logic [QB-1:0]    qin;
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            dsh = CMP_W'({(j == 0) ? den5_reg : dend_reg[j-1], {(QB-1){1'b0}}} >> j);
            for (int i = 0; i < NLANE; i++)
            begin
                rin = (j == 0) ? {1'b0, num5_reg[i]} : {1'b0, rem_reg[j-1][i]};
                qin = (j == 0) ? '0 : q_reg[j-1][i];
                if (rin >= dsh)
                begin
                    rem_next[j][i] = NUM_W'(rin - dsh);
                    q_next[j][i]   = qin | (QB'(1) << (QB - 1 - j));
                end
                else
                begin
                    rem_next[j][i] = rin[NUM_W-1:0];
                    q_next[j][i]   = qin;
                end
            end
        end
    end

    always_comb
    begin
        logic [QB-1:0]          mag;
        logic signed [ACC_W-1:0] corr;
        logic signed [ACC_W-1:0] acc;
        logic                   neg;
        carry_t                 cl;
        cl = cd_reg[DIV_STEPS-1];
        for (int i = 0; i < NLANE; i++)
        begin
            mag  = q_reg[DIV_STEPS-1][i][QB-1] ? (QB'(1) << (QB - 1))
                                               : q_reg[DIV_STEPS-1][i];
            neg  = cl.dotn ^ (((i % 2) == 0) ? cl.dxn : cl.dyn);
            corr = neg ? (ACC_W'(0) - ACC_W'(mag)) : ACC_W'(mag);
            if (i < 2)
            begin
                acc = ACC_W'(signed'(cl.v[i])) - corr;
            end
            else
            begin
                acc = ACC_W'(signed'(cl.v[i])) + corr;
            end
            if (cl.bad)
            begin
                res_next[i] = cl.v[i];
            end
            else if (acc > ACC_W'(32767))
            begin
                res_next[i] = 16'sh7FFF;
            end
            else if (acc < -ACC_W'(32768))
            begin
                res_next[i] = 16'sh8000;
            end
            else
            begin
                res_next[i] = acc[V_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            // s0: differences and mass sum
            c0_reg.v    <= {vel_b_y, vel_b_x, vel_a_y, vel_a_x};
            c0_reg.bad  <= 1'b0;
            c0_reg.dxn  <= 1'b0;
            c0_reg.dyn  <= 1'b0;
            c0_reg.dotn <= 1'b0;
            dvx0_reg  <= {vel_a_x[V_W-1], vel_a_x} - {vel_b_x[V_W-1], vel_b_x};
            dvy0_reg  <= {vel_a_y[V_W-1], vel_a_y} - {vel_b_y[V_W-1], vel_b_y};
            dx0_reg   <= dx_in;
            dy0_reg   <= dy_in;
            msum0_reg <= {1'b0, mass_a} + {1'b0, mass_b};
            ma0_reg   <= mass_a;
            mb0_reg   <= mass_b;

            // s1: products, magnitudes, error check
            c1_reg.v    <= c0_reg.v;
            c1_reg.bad  <= (msum0_reg == '0) || ((dx0_reg == '0) && (dy0_reg == '0));
            c1_reg.dxn  <= dx0_reg[D_W-1];
            c1_reg.dyn  <= dy0_reg[D_W-1];
            c1_reg.dotn <= c0_reg.dotn;
            pxx1_reg  <= dvx0_reg * dx0_reg;
            pyy1_reg  <= dvy0_reg * dy0_reg;
            sxx1_reg  <= dx0_reg * dx0_reg;
            syy1_reg  <= dy0_reg * dy0_reg;
            adx1_reg  <= dx0_reg[D_W-1] ? V_W'(D_W'(0) - dx0_reg) : dx0_reg[V_W-1:0];
            ady1_reg  <= dy0_reg[D_W-1] ? V_W'(D_W'(0) - dy0_reg) : dy0_reg[V_W-1:0];
            ma1_reg   <= ma0_reg;
            mb1_reg   <= mb0_reg;
            msum1_reg <= msum0_reg;

            // s2: dot, squared length, mass times axis distance
            c2_reg     <= c1_reg;
            dot2_reg   <= {pxx1_reg[PROD_W-1], pxx1_reg} + {pyy1_reg[PROD_W-1], pyy1_reg};
            len2_reg   <= {1'b0, sxx1_reg[SQ_W-1:0]} + {1'b0, syy1_reg[SQ_W-1:0]};
            msum2_reg  <= msum1_reg;
            md2_reg[0] <= mb1_reg * adx1_reg;
            md2_reg[1] <= mb1_reg * ady1_reg;
            md2_reg[2] <= ma1_reg * adx1_reg;
            md2_reg[3] <= ma1_reg * ady1_reg;

            // s3: dot magnitude, denominator
            c3_reg.v    <= c2_reg.v;
            c3_reg.bad  <= c2_reg.bad;
            c3_reg.dxn  <= c2_reg.dxn;
            c3_reg.dyn  <= c2_reg.dyn;
            c3_reg.dotn <= dot2_reg[DOT_W-1];
            adot3_reg   <= dot2_reg[DOT_W-1] ? dot_neg[ADOT_W-1:0] : dot2_reg[ADOT_W-1:0];
            den3_reg    <= msum2_reg * len2_reg;
            md3_reg     <= md2_reg;

            // s4: split partial products
            c4_reg   <= c3_reg;
            den4_reg <= den3_reg;
            for (int i = 0; i < NLANE; i++)
            begin
                plo4_reg[i] <= md3_reg[i] * adot3_reg[LO_W-1:0];
                phi4_reg[i] <= md3_reg[i] * adot3_reg[ADOT_W-1:LO_W];
            end

            // s5: numerator, times two
            c5_reg   <= c4_reg;
            den5_reg <= den4_reg;
            for (int i = 0; i < NLANE; i++)
            begin
                num5_reg[i] <= {psum[i], 1'b0};
            end

            for (int j = 0; j < DIV_STEPS; j++)
            begin
                cd_reg[j]   <= (j == 0) ? c5_reg : cd_reg[j-1];
                dend_reg[j] <= (j == 0) ? den5_reg : dend_reg[j-1];
                rem_reg[j]  <= rem_next[j];
                q_reg[j]    <= q_next[j];
            end

            res_reg <= res_next;
            bad_reg <= cd_reg[DIV_STEPS-1].bad;
        end
    end

    assign out_valid   = vld_reg[NSTAGE-1];
    assign new_vel_a_x = res_reg[0];
    assign new_vel_a_y = res_reg[1];
    assign new_vel_b_x = res_reg[2];
    assign new_vel_b_y = res_reg[3];
    assign bad_pair    = bad_reg;

endmodule

`default_nettype wire

// ===== verif/collision_checker.sv =====
// Checker: watches both channels of the collision core, predicts and compares results.
`timescale 1ns / 1ps
`default_nettype none

module collision_checker
    import ecv_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_stall,
    input  wire logic signed [V_W-1:0] vel_a_x,
    input  wire logic signed [V_W-1:0] vel_a_y,
    input  wire logic signed [V_W-1:0] vel_b_x,
    input  wire logic signed [V_W-1:0] vel_b_y,
    input  wire logic        [V_W-1:0] mass_a,
    input  wire logic        [V_W-1:0] mass_b,
    input  wire logic signed [V_W-1:0] pos_a_x,
    input  wire logic signed [V_W-1:0] pos_a_y,
    input  wire logic signed [V_W-1:0] pos_b_x,
    input  wire logic signed [V_W-1:0] pos_b_y,
    input  wire logic                  out_valid,
    input  wire logic                  out_stall,
    input  wire logic signed [V_W-1:0] new_vel_a_x,
    input  wire logic signed [V_W-1:0] new_vel_a_y,
    input  wire logic signed [V_W-1:0] new_vel_b_x,
    input  wire logic signed [V_W-1:0] new_vel_b_y,
    input  wire logic                  bad_pair,
    output int                         fail_count,
    output int                         pending
);

    typedef struct packed {
        logic signed [V_W-1:0] vax;
        logic signed [V_W-1:0] vay;
        logic signed [V_W-1:0] vbx;
        logic signed [V_W-1:0] vby;
        logic                  bad;
    } velocities_t;

    velocities_t impact_q[$];

    function automatic logic signed [V_W-1:0] clamp16(input logic signed [127:0] v);
        if (v > 128'sd32767)
            return 16'sh7fff;
        if (v < -128'sd32768)
            return 16'sh8000;
        return v[V_W-1:0];
    endfunction

    // truncating signed quotient of 2*m*dot*delta / den
    function automatic logic signed [127:0] impulse(input logic signed [127:0] m,
                                                    input logic signed [127:0] dot,
                                                    input logic signed [127:0] delta,
                                                    input logic signed [127:0] den);
        logic signed [127:0] num;
        num = 128'sd2 * m * dot * delta;
        return num / den;
    endfunction

    function automatic velocities_t resolve_impact(
        input logic signed [V_W-1:0] ax, ay, bx, by,
        input logic [V_W-1:0] ma, mb,
        input logic signed [V_W-1:0] pax, pay, pbx, pby);
        velocities_t r;
        logic signed [127:0] dx, dy, dot, den, sa, sb;
        sa = $signed({1'b0, ma});
        sb = $signed({1'b0, mb});
        dx = 128'(pax) - 128'(pbx);
        dy = 128'(pay) - 128'(pby);
        r.vax = ax;
        r.vay = ay;
        r.vbx = bx;
        r.vby = by;
        r.bad = 1'b1;
        if (sa + sb == 0 || (dx == 0 && dy == 0))
            return r;
        dot = (128'(ax) - 128'(bx)) * dx + (128'(ay) - 128'(by)) * dy;
        den = (sa + sb) * (dx * dx + dy * dy);
        r.vax = clamp16(128'(ax) - impulse(sb, dot, dx, den));
        r.vay = clamp16(128'(ay) - impulse(sb, dot, dy, den));
        r.vbx = clamp16(128'(bx) + impulse(sa, dot, dx, den));
        r.vby = clamp16(128'(by) + impulse(sa, dot, dy, den));
        r.bad = 1'b0;
        return r;
    endfunction

    always @(posedge clk)
    begin
        velocities_t e;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                impact_q.push_back(resolve_impact(vel_a_x, vel_a_y, vel_b_x, vel_b_y,
                    mass_a, mass_b, pos_a_x, pos_a_y, pos_b_x, pos_b_y));
            if (out_valid && !out_stall)
            begin
                if (impact_q.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    fail_count++;
                end
                else
                begin
                    e = impact_q.pop_front();
                    if (new_vel_a_x !== e.vax)
                    begin
                        $error("new_vel_a_x expected %0d got %0d", e.vax, new_vel_a_x);
                        fail_count++;
                    end
                    if (new_vel_a_y !== e.vay)
                    begin
                        $error("new_vel_a_y expected %0d got %0d", e.vay, new_vel_a_y);
                        fail_count++;
                    end
                    if (new_vel_b_x !== e.vbx)
                    begin
                        $error("new_vel_b_x expected %0d got %0d", e.vbx, new_vel_b_x);
                        fail_count++;
                    end
                    if (new_vel_b_y !== e.vby)
                    begin
                        $error("new_vel_b_y expected %0d got %0d", e.vby, new_vel_b_y);
                        fail_count++;
                    end
                    if (bad_pair !== e.bad)
                    begin
                        $error("bad_pair expected %0b got %0b", e.bad, bad_pair);
                        fail_count++;
                    end
                end
            end
            pending = impact_q.size();
        end
    end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Testbench top: drives contact pairs into the collision core and reports the verdict.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
    import ecv_pkg::*;

    localparam int WATCHDOG = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [V_W-1:0] vel_a_x = '0, vel_a_y = '0, vel_b_x = '0, vel_b_y = '0;
    logic [V_W-1:0] mass_a = '0, mass_b = '0;
    logic signed [V_W-1:0] pos_a_x = '0, pos_a_y = '0, pos_b_x = '0, pos_b_y = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [V_W-1:0] new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y;
    logic bad_pair;
    int fail_count, pending;
    int send_idle_pct = 0, recv_stall_pct = 0;
    int quiet_cycles = 0;

    always #4 clk = ~clk;

    elastic_collision_2d_vector_core dut (.*);

    collision_checker u_checker (.*);

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [V_W-1:0] pick_value();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return V_W'($urandom_range(16) - 8);
            3: return V_W'($urandom_range(512) - 256);
            default: return V_W'($urandom);
        endcase
    endfunction

    // holds payload until transfer; valid stays high between back-to-back pairs
    task automatic send_pair(input logic [V_W-1:0] ax, ay, bx, by, ma, mb,
                             input logic [V_W-1:0] pax, pay, pbx, pby);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        vel_a_x <= ax; vel_a_y <= ay; vel_b_x <= bx; vel_b_y <= by;
        mass_a <= ma; mass_b <= mb;
        pos_a_x <= pax; pos_a_y <= pay; pos_b_x <= pbx; pos_b_y <= pby;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic send_random(input int count);
        logic [V_W-1:0] pax, pay;
        repeat (count)
        begin
            pax = pick_value();
            pay = pick_value();
            case ($urandom_range(9))
                0: send_pair(pick_value(), pick_value(), pick_value(), pick_value(),
                             pick_value(), pick_value(), pax, pay, pax, pay);
                1: send_pair(pick_value(), pick_value(), pick_value(), pick_value(),
                             16'd0, 16'd0, pax, pay, pick_value(), pick_value());
                2: send_pair(pick_value(), pick_value(), pick_value(), pick_value(),
                             pick_value(), pick_value(), pax, pay, pax, pick_value());
                default: send_pair(pick_value(), pick_value(), pick_value(), pick_value(),
                             pick_value(), pick_value(), pax, pay,
                             pick_value(), pick_value());
            endcase
        end
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0 || in_valid)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_pair(16'h0100, 16'h0000, 16'hff00, 16'h0000, 16'd1, 16'd1,
                  16'd0, 16'd0, 16'd10, 16'd0);
        send_pair(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'hffff, 16'hffff,
                  16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
        send_pair(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'hffff, 16'h0001,
                  16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        send_pair(16'h1234, 16'h5678, 16'h9abc, 16'hdef0, 16'd0, 16'd0,
                  16'd3, 16'd4, 16'd0, 16'd0);
        send_pair(16'h1234, 16'h5678, 16'h9abc, 16'hdef0, 16'd5, 16'd7,
                  16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        send_pair(16'h0200, 16'h0300, 16'h0000, 16'h0000, 16'd0, 16'd9,
                  16'd5, 16'd1, 16'd5, 16'd9);
        send_pair(16'h0200, 16'hff00, 16'h0100, 16'h0000, 16'd9, 16'd0,
                  16'd1, 16'd5, 16'd8, 16'd5);
        send_pair(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'd1, 16'hffff,
                  16'd0, 16'd0, 16'd1, 16'd1);
        send_pair(16'hffff, 16'hffff, 16'h0001, 16'h0001, 16'h8000, 16'h7fff,
                  16'hffff, 16'h0000, 16'h0000, 16'hffff);
        send_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd3, 16'd3,
                  16'd2, 16'd2, 16'd0, 16'd0);
        in_valid <= 1'b0;
        drain();

        send_random(150);
        send_idle_pct = 85;
        send_random(150);
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 85;
        send_random(150);
        send_idle_pct = 28;
        recv_stall_pct = 28;
        send_random(150);
        drain();

        repeat (40) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/ecv_pkg.sv
sv/elastic_collision_2d_vector_core.sv
verif/collision_checker.sv
verif/testbench.sv
